// ----- rtl/mwta_pkg.sv -----
// Shared constants, types and microcode table for the maxnet winner-take-all block.
package mwta_pkg;

   localparam int MAX_NODES = 16;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = IDX_W + 1;
   localparam int ACTN_W    = 5;
   localparam int NSAT_W    = (CNT_W > ACTN_W) ? CNT_W : ACTN_W;
   localparam int ACT_W     = 16;
   localparam int OUT_W     = 15;
   localparam int COEF_W    = 16;
   localparam int ROUND_W   = 16;
   localparam int ACC_W     = ACT_W + IDX_W;
   localparam int DIFF_W    = ACC_W + 1;
   localparam int PROD_W    = COEF_W + 1 + DIFF_W;
   localparam int SELF_SH   = 8;
   localparam int NET_W     = PROD_W + SELF_SH + 1;
   localparam int FRAC_SH   = 16;
   localparam int SAT_LSB   = FRAC_SH + OUT_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;
   localparam int PC_W      = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_NODES = 2'd0,
      CSR_INHIBITION   = 2'd1,
      CSR_SELF_WEIGHT  = 2'd2,
      CSR_ROUND_LIMIT  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      C_NEXT      = 3'd0,
      C_ALWAYS    = 3'd1,
      C_LOAD_WAIT = 3'd2,
      C_IDX_MORE  = 3'd3,
      C_OUT_BUSY  = 3'd4,
      C_AGAIN     = 3'd5
   } cond_type;

   localparam logic [PC_W-1:0] ST_LOAD      = 4'd0;
   localparam logic [PC_W-1:0] ST_ROUND     = 4'd1;
   localparam logic [PC_W-1:0] ST_SUM_RD    = 4'd2;
   localparam logic [PC_W-1:0] ST_SUM_ADD   = 4'd3;
   localparam logic [PC_W-1:0] ST_UPD_INIT  = 4'd4;
   localparam logic [PC_W-1:0] ST_UPD_RD    = 4'd5;
   localparam logic [PC_W-1:0] ST_MUL_SELF  = 4'd6;
   localparam logic [PC_W-1:0] ST_MUL_OTHER = 4'd7;
   localparam logic [PC_W-1:0] ST_UPD_WR    = 4'd8;
   localparam logic [PC_W-1:0] ST_ROUND_END = 4'd9;
   localparam logic [PC_W-1:0] ST_OUT_INIT  = 4'd10;
   localparam logic [PC_W-1:0] ST_OUT_RD    = 4'd11;
   localparam logic [PC_W-1:0] ST_OUT_EMIT  = 4'd12;
   localparam logic [PC_W-1:0] ST_OUT_NEXT  = 4'd13;
   localparam logic [PC_W-1:0] ST_DONE      = 4'd14;

   typedef struct packed {
      logic            ready;
      logic            idx_clr;
      logic            idx_inc;
      logic            ram_rd;
      logic            acc_clr;
      logic            acc_add;
      logic            mul_self;
      logic            mul_other;
      logic            upd_wr;
      logic            pos_clr;
      logic            round_clr;
      logic            round_inc;
      logic            flag_ld;
      logic            out_load;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic load_done;
      logic idx_more;
      logic out_busy;
      logic again;
   } cond_flags_type;

   typedef struct packed {
      logic [CNT_W-1:0]   n_total;
      logic [COEF_W-1:0]  inhibition;
      logic [COEF_W-1:0]  self_weight;
      logic [ROUND_W-1:0] round_limit;
   } cfg_type;

   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type cw;
      cw        = '0;
      cw.cond   = C_NEXT;
      cw.target = ST_LOAD;
      case (pc)
         ST_LOAD: begin
            cw.ready     = 1'b1;
            cw.round_clr = 1'b1;
            cw.cond      = C_LOAD_WAIT;
            cw.target    = ST_LOAD;
         end
         ST_ROUND: begin
            cw.idx_clr = 1'b1;
            cw.acc_clr = 1'b1;
            cw.pos_clr = 1'b1;
         end
         ST_SUM_RD: cw.ram_rd = 1'b1;
         ST_SUM_ADD: begin
            cw.acc_add = 1'b1;
            cw.idx_inc = 1'b1;
            cw.cond    = C_IDX_MORE;
            cw.target  = ST_SUM_RD;
         end
         ST_UPD_INIT:  cw.idx_clr   = 1'b1;
         ST_UPD_RD:    cw.ram_rd    = 1'b1;
         ST_MUL_SELF:  cw.mul_self  = 1'b1;
         ST_MUL_OTHER: cw.mul_other = 1'b1;
         ST_UPD_WR: begin
            cw.upd_wr  = 1'b1;
            cw.idx_inc = 1'b1;
            cw.cond    = C_IDX_MORE;
            cw.target  = ST_UPD_RD;
         end
         ST_ROUND_END: begin
            cw.round_inc = 1'b1;
            cw.flag_ld   = 1'b1;
            cw.cond      = C_AGAIN;
            cw.target    = ST_ROUND;
         end
         ST_OUT_INIT: cw.idx_clr = 1'b1;
         ST_OUT_RD:   cw.ram_rd  = 1'b1;
         ST_OUT_EMIT: begin
            cw.out_load = 1'b1;
            cw.cond     = C_OUT_BUSY;
            cw.target   = ST_OUT_EMIT;
         end
         ST_OUT_NEXT: begin
            cw.idx_inc = 1'b1;
            cw.cond    = C_IDX_MORE;
            cw.target  = ST_OUT_RD;
         end
         ST_DONE: begin
            cw.cond   = C_ALWAYS;
            cw.target = ST_LOAD;
         end
         default: begin
            cw.cond   = C_ALWAYS;
            cw.target = ST_LOAD;
         end
      endcase
      return cw;
   endfunction

endpackage

// ----- rtl/mwta_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mwta_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mwta_seq.sv -----
// Microcode sequencer: step counter, control store and conditional jumps.
module mwta_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  mwta_pkg::cond_flags_type flags,
   output mwta_pkg::ctrl_word_type  ctrl
);

   import mwta_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            taken;

   assign ctrl = ucode(pc_ff);

   always_comb begin
      case (ctrl.cond)
         C_NEXT:      taken = 1'b0;
         C_ALWAYS:    taken = 1'b1;
         C_LOAD_WAIT: taken = !flags.load_done;
         C_IDX_MORE:  taken = flags.idx_more;
         C_OUT_BUSY:  taken = flags.out_busy;
         C_AGAIN:     taken = flags.again;
         default:     taken = 1'b0;
      endcase
      pc_in = taken ? ctrl.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- rtl/mwta_dp.sv -----
// Datapath: activation store, sum, shared multiplier, update, counters and result register.
module mwta_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  mwta_pkg::ctrl_word_type         ctrl,
   input  mwta_pkg::cfg_type               cfg,
   output mwta_pkg::cond_flags_type        flags,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [mwta_pkg::ACT_W-1:0] req_activation_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mwta_pkg::IDX_W-1:0]      rsp_node_index,
   output logic [mwta_pkg::OUT_W-1:0]      rsp_activation_out,
   output logic                           rsp_last_node,
   output logic                           rsp_timed_out
);

   import mwta_pkg::*;

   logic                     accept;
   logic                     last_item;
   logic                     load_wr;
   logic [CNT_W-1:0]         load_count_ff, load_count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         n_last;
   logic                     idx_more;
   logic                     ram_wr;
   logic [IDX_W-1:0]         ram_waddr;
   logic [ACT_W-1:0]         ram_wdata;
   logic [ACT_W-1:0]         ram_rdata;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [DIFF_W-1:0] rd_ext, acc_ext;
   logic [COEF_W-1:0]        mul_a;
   logic signed [DIFF_W-1:0] mul_b;
   logic signed [PROD_W-1:0] product;
   logic signed [PROD_W-1:0] self_ff, self_in, other_ff, other_in;
   logic signed [NET_W-1:0]  net;
   logic                     net_pos, net_sat;
   logic [ACT_W-1:0]         upd_value;
   logic                     upd_nonzero;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic [ROUND_W-1:0]       round_ff, round_in;
   logic [ROUND_W:0]         round_next;
   logic                     multi_pos;
   logic                     timed_ff, timed_in;
   logic                     out_free, out_take;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic [OUT_W-1:0]         rsp_act_ff;
   logic                     rsp_last_ff, rsp_timed_ff;

   assign accept    = req_valid && ctrl.ready;
   assign req_stall = !ctrl.ready;
   assign last_item = ({1'b0, load_count_ff} + 1'b1) >= {1'b0, cfg.n_total};
   assign load_wr   = accept && (load_count_ff < CNT_W'(MAX_NODES));

   always_comb begin
      load_count_in = load_count_ff;
      if (accept) begin
         load_count_in = last_item ? '0 : load_count_ff + 1'b1;
      end
   end

   assign n_last   = cfg.n_total - 1'b1;
   assign idx_more = idx_ff != n_last[IDX_W-1:0];

   always_comb begin
      idx_in = idx_ff;
      if (ctrl.idx_clr) begin
         idx_in = '0;
      end else if (ctrl.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   assign ram_wr    = load_wr || ctrl.upd_wr;
   assign ram_waddr = ctrl.upd_wr ? idx_ff : load_count_ff[IDX_W-1:0];
   assign ram_wdata = ctrl.upd_wr ? upd_value : req_activation_in;

   mwta_ram #(
      .WIDTH (ACT_W),
      .DEPTH (MAX_NODES)
   ) u_act_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ctrl.ram_rd),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign rd_ext  = DIFF_W'($signed(ram_rdata));
   assign acc_ext = DIFF_W'(acc_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_clr) begin
         acc_in = '0;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + ACC_W'($signed(ram_rdata));
      end
   end

   assign mul_a   = ctrl.mul_other ? cfg.inhibition : cfg.self_weight;
   assign mul_b   = ctrl.mul_other ? (acc_ext - rd_ext) : rd_ext;
   assign product = $signed({1'b0, mul_a}) * mul_b;

   assign self_in  = ctrl.mul_self ? product : self_ff;
   assign other_in = ctrl.mul_other ? product : other_ff;

   assign net = $signed({self_ff[PROD_W-1], self_ff, {SELF_SH{1'b0}}})
              - $signed({{(SELF_SH + 1){other_ff[PROD_W-1]}}, other_ff});

   assign net_pos = !net[NET_W-1] && (net != '0);
   assign net_sat = |net[NET_W-2:SAT_LSB];

   always_comb begin
      if (!net_pos) begin
         upd_value = '0;
      end else if (net_sat) begin
         upd_value = {1'b0, {OUT_W{1'b1}}};
      end else begin
         upd_value = {1'b0, net[SAT_LSB-1:FRAC_SH]};
      end
   end

   assign upd_nonzero = upd_value != '0;

   always_comb begin
      pos_in = pos_ff;
      if (ctrl.pos_clr) begin
         pos_in = '0;
      end else if (ctrl.upd_wr && upd_nonzero) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_comb begin
      round_in = round_ff;
      if (ctrl.round_clr) begin
         round_in = '0;
      end else if (ctrl.round_inc) begin
         round_in = round_ff + 1'b1;
      end
   end

   assign round_next = {1'b0, round_ff} + 1'b1;
   assign multi_pos  = pos_ff > CNT_W'(1);
   assign timed_in   = ctrl.flag_ld ? multi_pos : timed_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_take = ctrl.out_load && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         idx_ff        <= '0;
         pos_ff        <= '0;
         round_ff      <= '0;
         timed_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         idx_ff        <= idx_in;
         pos_ff        <= pos_in;
         round_ff      <= round_in;
         timed_ff      <= timed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      self_ff  <= self_in;
      other_ff <= other_in;
      if (out_take) begin
         rsp_index_ff <= idx_ff;
         rsp_act_ff   <= ram_rdata[OUT_W-1:0];
         rsp_last_ff  <= !idx_more;
         rsp_timed_ff <= timed_ff;
      end
   end

   assign flags.load_done = accept && last_item;
   assign flags.idx_more  = idx_more;
   assign flags.out_busy  = !out_free;
   assign flags.again     = multi_pos && ({1'b0, round_next} < {1'b0, 1'b0, cfg.round_limit});

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_node_index     = rsp_index_ff;
   assign rsp_activation_out = rsp_act_ff;
   assign rsp_last_node      = rsp_last_ff;
   assign rsp_timed_out      = rsp_timed_ff;

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.out_load))
      else $error("result raised without an emit step");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.ram_rd |-> ({1'b0, idx_ff} <= n_last))
      else $error("read index past node count");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      ctrl.upd_wr |-> !load_wr)
      else $error("load and update write in the same cycle");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (flags.idx_more == idx_more) && ($past(last_item) || !ctrl.ram_rd))
      else $error("datapath read during partial load");

endmodule

// ----- rtl/maxnet_winner_take_all.sv -----
// Maxnet winner-take-all top level: configuration registers, sequencer and datapath.
//
// Usage:
//   req_*  loads one signed Q8.8 activation per transaction, in node order.
//          When the n-th activation arrives (n = active_nodes, limited to
//          1..16) the competition starts and req_stall stays high until all
//          results have been handed to the rsp register and the wrap-up is done.
//   rsp_*  gives n transactions, node 0 first, with the final nonnegative
//          activation; rsp_last_node marks node n-1, rsp_timed_out is the
//          same on all results of a run.
//   csr_*  writes active_nodes, inhibition, self_weight, round_limit by index;
//          csr_ready is always high. Write only while no competition runs.
// Timing: a load accepts one item per cycle. Each round walks the activation
//   RAM twice through its single read port. The rounds are data dependent,
//   from 1 up to round_limit (1 when round_limit is 0). Results leave one
//   at a time when not stalled, followed by a wrap-up step before loading.
// Reset returns the sequencer to loading, clears the load count and sets
//   the registers to their defaults. A stalled result holds its register
//   and the sequencer waits at the emit step.
module maxnet_winner_take_all (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [mwta_pkg::ACT_W-1:0]  req_activation_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mwta_pkg::IDX_W-1:0]          rsp_node_index,
   output logic [mwta_pkg::OUT_W-1:0]          rsp_activation_out,
   output logic                               rsp_last_node,
   output logic                               rsp_timed_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mwta_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mwta_pkg::CSR_W-1:0]          csr_wdata
);

   import mwta_pkg::*;

   logic [ACTN_W-1:0]  active_nodes_ff, active_nodes_in;
   logic [COEF_W-1:0]  inhibition_ff, inhibition_in;
   logic [COEF_W-1:0]  self_weight_ff, self_weight_in;
   logic [ROUND_W-1:0] round_limit_ff, round_limit_in;
   logic [NSAT_W-1:0]  active_ext;
   logic [CNT_W-1:0]   n_total;
   logic               csr_write;
   cfg_type            cfg;
   ctrl_word_type      ctrl;
   cond_flags_type     flags;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      active_nodes_in = active_nodes_ff;
      inhibition_in   = inhibition_ff;
      self_weight_in  = self_weight_ff;
      round_limit_in  = round_limit_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ACTIVE_NODES: active_nodes_in = csr_wdata[ACTN_W-1:0];
            CSR_INHIBITION:   inhibition_in   = csr_wdata[COEF_W-1:0];
            CSR_SELF_WEIGHT:  self_weight_in  = csr_wdata[COEF_W-1:0];
            CSR_ROUND_LIMIT:  round_limit_in  = csr_wdata[ROUND_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_nodes_ff <= ACTN_W'(16);
         inhibition_ff   <= COEF_W'(4096);
         self_weight_ff  <= COEF_W'(256);
         round_limit_ff  <= ROUND_W'(1024);
      end else begin
         active_nodes_ff <= active_nodes_in;
         inhibition_ff   <= inhibition_in;
         self_weight_ff  <= self_weight_in;
         round_limit_ff  <= round_limit_in;
      end
   end

   assign active_ext = NSAT_W'(active_nodes_ff);

   always_comb begin
      if (active_ext == '0) begin
         n_total = CNT_W'(1);
      end else if (active_ext > NSAT_W'(MAX_NODES)) begin
         n_total = CNT_W'(MAX_NODES);
      end else begin
         n_total = active_ext[CNT_W-1:0];
      end
   end

   assign cfg.n_total     = n_total;
   assign cfg.inhibition  = inhibition_ff;
   assign cfg.self_weight = self_weight_ff;
   assign cfg.round_limit = round_limit_ff;

   mwta_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   mwta_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .cfg                (cfg),
      .flags              (flags),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_activation_in  (req_activation_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_node_index     (rsp_node_index),
      .rsp_activation_out (rsp_activation_out),
      .rsp_last_node      (rsp_last_node),
      .rsp_timed_out      (rsp_timed_out)
   );

endmodule

// ----- tb/maxnet_winner_take_all_test.sv -----
// Self-checking testbench for the maxnet winner-take-all block.
`timescale 1ns / 100ps

module maxnet_winner_take_all_test;
   import mwta_pkg::*;

   localparam int RESET_CYCLES   = 8;
   localparam int WRAP_UP_CYCLES = 4;
   localparam int END_CYCLES     = 40;
   localparam int CYCLE_LIMIT    = 8_000_000;

   typedef enum int {
      STYLE_NOISE,
      STYLE_SMALL,
      STYLE_CLOSE,
      STYLE_ONE_STRONG
   } data_style_type;

   typedef struct {
      logic [IDX_W-1:0] node_index;
      logic [OUT_W-1:0] activation_out;
      logic             last_node;
      logic             timed_out;
   } node_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [ACT_W-1:0]  req_activation_in;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [IDX_W-1:0]         rsp_node_index;
   logic [OUT_W-1:0]         rsp_activation_out;
   logic                     rsp_last_node;
   logic                     rsp_timed_out;
   logic                     csr_valid;
   logic                     csr_ready;
   csr_index_type            csr_index;
   logic [CSR_W-1:0]         csr_wdata;

   logic [ACTN_W-1:0]        reg_active_nodes;
   logic [COEF_W-1:0]        reg_inhibition;
   logic [COEF_W-1:0]        reg_self_weight;
   logic [ROUND_W-1:0]       reg_round_limit;
   int                       node_act [MAX_NODES];
   int unsigned              loaded_count;
   node_result_type          pending_node_results[$];

   int                       error_count;
   int                       cycle_count;
   bit                       sender_idles;
   bit                       receiver_idles;

   maxnet_winner_take_all u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_activation_in  (req_activation_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_node_index     (rsp_node_index),
      .rsp_activation_out (rsp_activation_out),
      .rsp_last_node      (rsp_last_node),
      .rsp_timed_out      (rsp_timed_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void reset_predictor();
      reg_active_nodes = ACTN_W'(16);
      reg_inhibition   = COEF_W'(4096);
      reg_self_weight  = COEF_W'(256);
      reg_round_limit  = ROUND_W'(1024);
      foreach (node_act[j]) node_act[j] = 0;
      loaded_count = 0;
   endfunction

   function automatic int unsigned competing_nodes();
      int unsigned n;
      n = reg_active_nodes;
      if (n < 1) n = 1;
      if (n > MAX_NODES) n = MAX_NODES;
      return n;
   endfunction

   function automatic int unsigned compete_round(input int unsigned n);
      longint total;
      longint self_term;
      longint other_term;
      longint net;
      longint q;
      int     next_act [MAX_NODES];
      int unsigned positives;
      total = 0;
      positives = 0;
      for (int j = 0; j < n; j++) total += node_act[j];
      for (int j = 0; j < n; j++) begin
         self_term  = longint'(reg_self_weight) * longint'(node_act[j]) * 256;
         other_term = longint'(reg_inhibition) * (total - longint'(node_act[j]));
         net = self_term - other_term;
         next_act[j] = 0;
         if (net > 0) begin
            q = net >>> FRAC_SH;
            next_act[j] = (q > 32767) ? 32767 : int'(q);
         end
         if (next_act[j] > 0) positives++;
      end
      for (int j = 0; j < n; j++) node_act[j] = next_act[j];
      return positives;
   endfunction

   function automatic void load_activation(input logic signed [ACT_W-1:0] value);
      int unsigned     n;
      int unsigned     rounds;
      int unsigned     positives;
      node_result_type res;
      n = competing_nodes();
      if (loaded_count < MAX_NODES) node_act[loaded_count] = int'(value);
      if (loaded_count + 1 < n) begin
         loaded_count++;
         return;
      end
      loaded_count = 0;
      rounds = 0;
      do begin
         positives = compete_round(n);
         rounds++;
      end while (positives > 1 && rounds < reg_round_limit);
      for (int k = 0; k < n; k++) begin
         res.node_index     = IDX_W'(k);
         res.activation_out = node_act[k][OUT_W-1:0];
         res.last_node      = (k + 1 == n);
         res.timed_out      = (positives > 1);
         pending_node_results.push_back(res);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      node_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_node_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result for node %0d", rsp_node_index));
         end else begin
            want = pending_node_results.pop_front();
            if (rsp_node_index !== want.node_index)
               report_mismatch($sformatf("node_index %0d, expected %0d",
                                         rsp_node_index, want.node_index));
            if (rsp_activation_out !== want.activation_out)
               report_mismatch($sformatf("node %0d activation_out %0d, expected %0d",
                                         want.node_index, rsp_activation_out,
                                         want.activation_out));
            if (rsp_last_node !== want.last_node)
               report_mismatch($sformatf("node %0d last_node %0b, expected %0b",
                                         want.node_index, rsp_last_node, want.last_node));
            if (rsp_timed_out !== want.timed_out)
               report_mismatch($sformatf("node %0d timed_out %0b, expected %0b",
                                         want.node_index, rsp_timed_out, want.timed_out));
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_idles && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_activation(input logic signed [ACT_W-1:0] value);
      int gap;
      @(negedge clock);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_activation_in <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      load_activation(value);
   endtask

   task automatic write_csr(input csr_index_type reg_sel, input logic [CSR_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= reg_sel;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (reg_sel)
         CSR_ACTIVE_NODES: reg_active_nodes = value[ACTN_W-1:0];
         CSR_INHIBITION:   reg_inhibition   = value[COEF_W-1:0];
         CSR_SELF_WEIGHT:  reg_self_weight  = value[COEF_W-1:0];
         CSR_ROUND_LIMIT:  reg_round_limit  = value[ROUND_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drain outstanding results, then let the sequencer finish its wrap-up
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_node_results.size() != 0) @(posedge clock);
      repeat (WRAP_UP_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [ACT_W-1:0] random_activation(input data_style_type style,
                                                                 input int center);
      case (style)
         STYLE_NOISE: return ACT_W'($urandom);
         STYLE_SMALL: return ACT_W'($urandom_range(0, 4000));
         STYLE_CLOSE: return ACT_W'(center + int'($urandom_range(0, 64)) - 32);
         default: begin
            if ($urandom_range(0, 3) == 0) return ACT_W'($urandom_range(0, 32767));
            return ACT_W'(-int'($urandom_range(1, 32768)));
         end
      endcase
   endfunction

   task automatic test_reset_defaults();
      logic signed [ACT_W-1:0] vals [16] = '{
         16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555, 16'shAAAA, 16'sd256,
         16'sd12000, 16'sd11990, -16'sd300, 16'sd2, 16'sd8000, 16'sd30000, 16'sd29999,
         16'sd100};
      foreach (vals[i]) send_activation(vals[i]);
      wait_for_results();
   endtask

   task automatic test_single_node();
      write_csr(CSR_ROUND_LIMIT, 16'hFFFF);
      write_csr(CSR_ACTIVE_NODES, 16'hFFE1);
      send_activation(16'sh7FFF);
      wait_for_results();
      write_csr(CSR_ACTIVE_NODES, 16'h0000);
      write_csr(CSR_SELF_WEIGHT, 16'h0000);
      send_activation(16'sd77);
      wait_for_results();
   endtask

   task automatic test_round_limit_zero();
      write_csr(CSR_ACTIVE_NODES, 16'd2);
      write_csr(CSR_INHIBITION, 16'd4096);
      write_csr(CSR_SELF_WEIGHT, 16'd256);
      write_csr(CSR_ROUND_LIMIT, 16'd0);
      send_activation(16'sd1000);
      send_activation(16'sd900);
      wait_for_results();
   endtask

   task automatic test_fixed_point_stall();
      write_csr(CSR_ACTIVE_NODES, 16'd3);
      write_csr(CSR_INHIBITION, 16'd0);
      write_csr(CSR_ROUND_LIMIT, 16'd7);
      send_activation(16'sd300);
      send_activation(16'sd200);
      send_activation(-16'sd5);
      wait_for_results();
   endtask

   task automatic test_saturation();
      write_csr(CSR_ACTIVE_NODES, 16'd2);
      write_csr(CSR_INHIBITION, 16'hFFFF);
      write_csr(CSR_SELF_WEIGHT, 16'hFFFF);
      write_csr(CSR_ROUND_LIMIT, 16'd8);
      send_activation(16'sh7FFF);
      send_activation(16'sh8000);
      wait_for_results();
   endtask

   task automatic test_node_count_lowered();
      write_csr(CSR_ACTIVE_NODES, 16'd16);
      write_csr(CSR_INHIBITION, 16'd8192);
      write_csr(CSR_SELF_WEIGHT, 16'd256);
      write_csr(CSR_ROUND_LIMIT, 16'd50);
      send_activation(16'sd500);
      send_activation(16'sd700);
      send_activation(16'sd100);
      wait_for_results();
      write_csr(CSR_ACTIVE_NODES, 16'd2);
      send_activation(16'sd9999);
      wait_for_results();
   endtask

   task automatic randomize_settings();
      int nodes;
      int limit;
      case ($urandom_range(0, 19))
         0:       nodes = 0;
         1, 2:    nodes = $urandom_range(17, 31);
         3, 4, 5: nodes = 16;
         default: nodes = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 19))
         0:          limit = 0;
         1, 2, 3:    limit = $urandom_range(41, 300);
         default:    limit = $urandom_range(1, 40);
      endcase
      write_csr(CSR_ACTIVE_NODES, (16'($urandom) & 16'hFFE0) | 16'(nodes));
      write_csr(CSR_INHIBITION, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(1000, 20000)));
      write_csr(CSR_SELF_WEIGHT, ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(200, 300)));
      write_csr(CSR_ROUND_LIMIT, 16'(limit));
   endtask

   task automatic run_random_phases(input int item_goal);
      int             sent;
      int unsigned    n;
      int             partial;
      int             shorter;
      int             center;
      data_style_type style;
      sent = 0;
      while (sent < item_goal) begin
         wait_for_results();
         randomize_settings();
         repeat ($urandom_range(1, 4)) begin
            n      = competing_nodes();
            style  = data_style_type'($urandom_range(0, 3));
            center = $urandom_range(100, 30000);
            if (n > 1 && $urandom_range(0, 9) == 0) begin
               // broken load: cut the node count short partway through
               partial = $urandom_range(1, n - 1);
               repeat (partial) send_activation(random_activation(style, center));
               wait_for_results();
               shorter = $urandom_range(0, partial);
               write_csr(CSR_ACTIVE_NODES, (16'($urandom) & 16'hFFE0) | 16'(shorter));
               send_activation(random_activation(STYLE_NOISE, center));
               sent += partial + 1;
            end else begin
               repeat (n) send_activation(random_activation(style, center));
               sent += n;
            end
            if ($urandom_range(0, 7) == 0) wait_for_results();
         end
      end
   endtask

   task automatic test_random_competitions();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      run_random_phases(320);
   endtask

   task automatic test_random_no_idle();
      wait_for_results();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      run_random_phases(80);
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_activation_in = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_ACTIVE_NODES;
      csr_wdata         = '0;
      error_count       = 0;
      sender_idles      = 1'b1;
      receiver_idles    = 1'b1;
      reset_predictor();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_single_node();
      test_round_limit_zero();
      test_fixed_point_stall();
      test_saturation();
      test_node_count_lowered();
      test_random_competitions();
      test_random_no_idle();

      wait_for_results();
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
